FILE: rtl/core/dps_pkg.sv
// ----------------------------------------------------------------------------
// dps_pkg
// Shared constants and types for the dynamic priority scheduler.
// ----------------------------------------------------------------------------
package dps_pkg;

  // Default sizing
  localparam int SLOT_COUNT_DEF    = 8;
  localparam int PRIORITY_BITS_DEF = 16;
  localparam int TIME_BITS_DEF     = 8;

  // Fixed item field widths
  localparam int OP_W       = 1;
  localparam int SLOT_W     = 3;
  localparam int IN_PRIO_W  = 16;
  localparam int IN_TIME_W  = 8;
  localparam int CNT_W      = 9;
  localparam int AMT_W      = 8;
  localparam int OUT_PRIO_W = 16;
  localparam int OUT_CNT_W  = 4;
  localparam int CFG_IDX_W  = 8;

  // Stream widths (whole bytes)
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 32;

  // Operation codes
  localparam logic [OP_W-1:0] OP_LOAD = 1'b0;
  localparam logic [OP_W-1:0] OP_TICK = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RUN_PENALTY = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AGING_STEP  = 8'd1;

  // Reset values of configuration registers
  localparam logic [AMT_W-1:0] RUN_PENALTY_RST = 8'd3;
  localparam logic [AMT_W-1:0] AGING_STEP_RST  = 8'd1;

  // Slot status
  typedef enum logic [1:0] {
    ST_EMPTY    = 2'd0,
    ST_READY    = 2'd1,
    ST_BLOCKED  = 2'd2,
    ST_FINISHED = 2'd3
  } status_t;

  // Shared priority unit operation
  typedef enum logic {
    PU_ADD = 1'b0,
    PU_SUB = 1'b1
  } pu_op_t;

endpackage

FILE: rtl/core/dps_slot_mem.sv
// ----------------------------------------------------------------------------
// dps_slot_mem
// Slot record store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module dps_slot_mem #(
  parameter int WIDTH = 48,
  parameter int DEPTH = dps_pkg::SLOT_COUNT_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  import dps_pkg::*;

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: rtl/core/dps_prio_unit.sv
// ----------------------------------------------------------------------------
// dps_prio_unit
// Shared saturating add/subtract of an 8-bit amount on a signed priority.
// ----------------------------------------------------------------------------
module dps_prio_unit #(
  parameter int PRIORITY_BITS = dps_pkg::PRIORITY_BITS_DEF
) (
  input  dps_pkg::pu_op_t                  op,
  input  logic signed [PRIORITY_BITS-1:0]  a,
  input  logic [dps_pkg::AMT_W-1:0]        amt,
  output logic signed [PRIORITY_BITS-1:0]  y
);
  import dps_pkg::*;

  localparam int SW = PRIORITY_BITS + 2;
  localparam logic signed [SW-1:0] PMAX =
    SW'((64'sd1 <<< (PRIORITY_BITS - 1)) - 64'sd1);
  localparam logic signed [SW-1:0] PMIN = -PMAX - SW'(1);

  logic signed [SW-1:0] a_x;
  logic signed [SW-1:0] b_x;
  logic signed [SW-1:0] sum;

  always_comb begin
    a_x = SW'(a);
    b_x = $signed(SW'(amt));
    sum = (op == PU_SUB) ? (a_x - b_x) : (a_x + b_x);
    if (sum > PMAX) begin
      y = PMAX[PRIORITY_BITS-1:0];
    end else if (sum < PMIN) begin
      y = PMIN[PRIORITY_BITS-1:0];
    end else begin
      y = sum[PRIORITY_BITS-1:0];
    end
  end

endmodule

FILE: rtl/core/dynamic_priority_scheduler.sv
// ----------------------------------------------------------------------------
// dynamic_priority_scheduler
// Process slot table with highest-priority selection, run penalty and aging.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake                      payload
//  --------  ---  -----------------------------  ------------------------------
//  s_axis    in   s_axis_tvalid / s_axis_tready  tuser: operation
//                                                tdata: slot, priority, times
//  m_axis    out  m_axis_tvalid / m_axis_tready  tuser: ran
//                                                tdata: tick outcome, counts
//  cfg       in   cfg_valid / cfg_ready          cfg_index, cfg_data
//
//  The slot record memory has a single read port, so slots are handled one
//  at a time: a load writes its record and then counts, and a tick
//  walks every slot once to pick the winner, once to update, and once more
//  over the status flops to count. One item is in work at a time; tready is
//  high only while the sequencer is idle. A finished result sits in the
//  output register, so the next item is taken while it waits; the sequencer
//  holds only if a second result is ready before the first was taken.
//  rst is synchronous: all slots empty, registers to 3 and 1. cfg_ready is
//  always high.
//
module dynamic_priority_scheduler #(
  parameter int SLOT_COUNT    = dps_pkg::SLOT_COUNT_DEF,
  parameter int PRIORITY_BITS = dps_pkg::PRIORITY_BITS_DEF,
  parameter int TIME_BITS     = dps_pkg::TIME_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // input items
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [2:0] slot, [18:3] initial_priority, [26:19] needed_time,
  // [35:27] slices_before_block, [43:36] block_length
  input  logic [dps_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // [0] operation
  input  logic [0:0]                        s_axis_tuser,
  // result items
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [2:0] running_slot, [18:3] running_priority, [19] became_blocked,
  // [20] became_finished, [24:21] ready_count, [25] all_done
  output logic [dps_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // [0] ran
  output logic [0:0]                        m_axis_tuser,
  // configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [dps_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dps_pkg::AMT_W-1:0]         cfg_data
);
  import dps_pkg::*;

  localparam int IDX_W  = $clog2(SLOT_COUNT);
  localparam int CTR_W  = IDX_W + 1;
  localparam int RCNT_W = $clog2(SLOT_COUNT + 1);
  localparam int SX_W   = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
  localparam int RC_X_W = (RCNT_W > OUT_CNT_W) ? RCNT_W : OUT_CNT_W;
  localparam int PL_W   = (PRIORITY_BITS > IN_PRIO_W) ? PRIORITY_BITS : IN_PRIO_W;
  localparam int PO_W   = (PRIORITY_BITS > OUT_PRIO_W) ? PRIORITY_BITS : OUT_PRIO_W;
  localparam int TL_W   = (TIME_BITS > IN_TIME_W) ? TIME_BITS : IN_TIME_W;

  localparam logic signed [PL_W-1:0] LD_PMAX =
    PL_W'((64'sd1 <<< (PRIORITY_BITS - 1)) - 64'sd1);
  localparam logic signed [PL_W-1:0] LD_PMIN = -LD_PMAX - PL_W'(1);
  localparam logic [TL_W-1:0] LD_TMAX = TL_W'((64'd1 << TIME_BITS) - 64'd1);
  localparam logic [TIME_BITS-1:0] TMAX = '1;

  typedef struct packed {
    logic signed [PRIORITY_BITS-1:0] prio;
    logic [TIME_BITS-1:0]            cpu;
    logic [TIME_BITS-1:0]            rem;
    logic signed [CNT_W-1:0]         cnt;
    logic [TIME_BITS-1:0]            left;
  } rec_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_SEL,
    S_UPD,
    S_COUNT,
    S_OUT
  } state_t;

  state_t state;

  // config registers
  logic [AMT_W-1:0] run_penalty;
  logic [AMT_W-1:0] aging_step;

  // latched item
  logic [SLOT_W-1:0]           in_slot;
  logic signed [IN_PRIO_W-1:0] in_prio;
  logic [IN_TIME_W-1:0]        in_needed;
  logic signed [CNT_W-1:0]     in_sbb;
  logic [IN_TIME_W-1:0]        in_blen;

  // sequencer
  status_t           status [SLOT_COUNT];
  logic [CTR_W-1:0]  ctr;
  logic [CTR_W-1:0]  ctr_m1;
  logic [IDX_W-1:0]  ev;
  logic              found;
  logic [IDX_W-1:0]  best_idx;
  logic signed [PRIORITY_BITS-1:0] best_prio;
  logic [RCNT_W-1:0] ready_cnt;
  logic [RCNT_W-1:0] live_cnt;

  // result being built
  logic                            res_ran;
  logic signed [PRIORITY_BITS-1:0] res_prio;
  logic                            res_blk;
  logic                            res_fin;

  // memory ports
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  rec_t             wr_rec;
  logic [IDX_W-1:0] rd_addr;
  rec_t             rd_rec;

  // shared priority unit
  pu_op_t                          pu_op;
  logic signed [PRIORITY_BITS-1:0] pu_y;

  // load conversions
  logic [SX_W-1:0]                 slot_x;
  logic [IDX_W-1:0]                load_idx;
  logic                            load_ok;
  logic signed [PL_W-1:0]          ld_prio_x;
  logic [TL_W-1:0]                 ld_need_x;
  logic [TL_W-1:0]                 ld_blen_x;
  rec_t                            load_rec;

  // per-slot update
  logic     is_run;
  rec_t     upd_rec;
  status_t  st_new;
  logic     goes_blk;

  // output formatting
  logic [SX_W-1:0]        oslot_x;
  logic signed [PO_W-1:0] oprio_x;
  logic [RC_X_W-1:0]      ocnt_x;

  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready     = 1'b1;

  assign ctr_m1  = ctr - CTR_W'(1);
  assign ev      = ctr_m1[IDX_W-1:0];
  assign rd_addr = ctr[IDX_W-1:0];

  dps_slot_mem #(
    .WIDTH ($bits(rec_t)),
    .DEPTH (SLOT_COUNT)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_rec),
    .rd_addr (rd_addr),
    .rd_data (rd_rec)
  );

  assign is_run = found && (ev == best_idx);
  assign pu_op  = is_run ? PU_SUB : PU_ADD;

  dps_prio_unit #(
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_pu (
    .op  (pu_op),
    .a   (rd_rec.prio),
    .amt (is_run ? run_penalty : aging_step),
    .y   (pu_y)
  );

  // load item: clamp to configured widths
  always_comb begin
    slot_x   = SX_W'(in_slot);
    load_idx = slot_x[IDX_W-1:0];
    load_ok  = (32'(in_slot) < SLOT_COUNT);

    ld_prio_x = PL_W'(in_prio);
    ld_need_x = TL_W'(in_needed);
    ld_blen_x = TL_W'(in_blen);

    if (ld_prio_x > LD_PMAX) begin
      load_rec.prio = LD_PMAX[PRIORITY_BITS-1:0];
    end else if (ld_prio_x < LD_PMIN) begin
      load_rec.prio = LD_PMIN[PRIORITY_BITS-1:0];
    end else begin
      load_rec.prio = ld_prio_x[PRIORITY_BITS-1:0];
    end
    load_rec.cpu  = '0;
    load_rec.rem  = (ld_need_x > LD_TMAX) ? TMAX : ld_need_x[TIME_BITS-1:0];
    load_rec.cnt  = in_sbb;
    load_rec.left = (ld_blen_x > LD_TMAX) ? TMAX : ld_blen_x[TIME_BITS-1:0];
  end

  // tick update of one slot, record straight from the memory
  always_comb begin
    upd_rec  = rd_rec;
    st_new   = status[ev];
    goes_blk = 1'b0;
    if (is_run) begin
      upd_rec.prio = pu_y;
      if (rd_rec.cpu != TMAX) begin
        upd_rec.cpu = rd_rec.cpu + TIME_BITS'(1);
      end
      if (rd_rec.rem != '0) begin
        upd_rec.rem = rd_rec.rem - TIME_BITS'(1);
      end
      if (rd_rec.cnt > 0) begin
        upd_rec.cnt = rd_rec.cnt - CNT_W'(1);
        goes_blk    = (rd_rec.cnt == CNT_W'(1));
      end
      if (upd_rec.rem == '0) begin
        st_new = ST_FINISHED;
      end else if (goes_blk) begin
        st_new = ST_BLOCKED;
      end
    end else if (status[ev] == ST_READY && found) begin
      upd_rec.prio = pu_y;
    end else if (status[ev] == ST_BLOCKED) begin
      if (rd_rec.left != '0) begin
        upd_rec.left = rd_rec.left - TIME_BITS'(1);
      end
      if (upd_rec.left == '0) begin
        st_new = ST_READY;
      end
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ev;
    wr_rec  = upd_rec;
    if (state == S_LOAD) begin
      wr_en   = load_ok;
      wr_addr = load_idx;
      wr_rec  = load_rec;
    end else if (state == S_UPD) begin
      wr_en = (ctr != '0);
    end
  end

  always_comb begin
    oslot_x = SX_W'(best_idx);
    oprio_x = PO_W'(res_prio);
    ocnt_x  = RC_X_W'(ready_cnt);
  end

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      run_penalty <= RUN_PENALTY_RST;
      aging_step  <= AGING_STEP_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_RUN_PENALTY: run_penalty <= cfg_data;
        REG_AGING_STEP:  aging_step  <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      ctr           <= '0;
      found         <= 1'b0;
      m_axis_tvalid <= 1'b0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        status[i] <= ST_EMPTY;
      end
    end else begin
      // output register: load a new result or drop the one just taken
      if (state == S_OUT && (!m_axis_tvalid || m_axis_tready)) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            in_slot   <= s_axis_tdata[2:0];
            in_prio   <= s_axis_tdata[18:3];
            in_needed <= s_axis_tdata[26:19];
            in_sbb    <= s_axis_tdata[35:27];
            in_blen   <= s_axis_tdata[43:36];
            res_ran   <= 1'b0;
            res_prio  <= '0;
            res_blk   <= 1'b0;
            res_fin   <= 1'b0;
            found     <= 1'b0;
            best_idx  <= '0;
            ctr       <= '0;
            state     <= (s_axis_tuser == OP_TICK) ? S_SEL : S_LOAD;
          end
        end
        S_LOAD: begin
          if (load_ok) begin
            status[load_idx] <= ST_READY;
          end
          ready_cnt <= '0;
          live_cnt  <= '0;
          state     <= S_COUNT;
        end
        S_SEL: begin
          // read slot ctr, judge slot ctr-1; strict compare keeps lowest slot
          if (ctr != '0 && status[ev] == ST_READY &&
              (!found || rd_rec.prio > best_prio)) begin
            found     <= 1'b1;
            best_idx  <= ev;
            best_prio <= rd_rec.prio;
          end
          if (ctr == CTR_W'(SLOT_COUNT)) begin
            ctr   <= '0;
            state <= S_UPD;
          end else begin
            ctr <= ctr + CTR_W'(1);
          end
        end
        S_UPD: begin
          if (ctr != '0) begin
            status[ev] <= st_new;
            if (is_run) begin
              res_ran  <= 1'b1;
              res_prio <= upd_rec.prio;
              res_blk  <= (st_new == ST_BLOCKED);
              res_fin  <= (st_new == ST_FINISHED);
            end
          end
          if (ctr == CTR_W'(SLOT_COUNT)) begin
            ctr       <= '0;
            ready_cnt <= '0;
            live_cnt  <= '0;
            state     <= S_COUNT;
          end else begin
            ctr <= ctr + CTR_W'(1);
          end
        end
        S_COUNT: begin
          if (status[rd_addr] == ST_READY) begin
            ready_cnt <= ready_cnt + RCNT_W'(1);
            live_cnt  <= live_cnt + RCNT_W'(1);
          end else if (status[rd_addr] == ST_BLOCKED) begin
            live_cnt <= live_cnt + RCNT_W'(1);
          end
          if (ctr == CTR_W'(SLOT_COUNT - 1)) begin
            state <= S_OUT;
          end else begin
            ctr <= ctr + CTR_W'(1);
          end
        end
        S_OUT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tuser <= res_ran;
            m_axis_tdata <= {6'd0,
                             (live_cnt == '0),
                             ocnt_x[OUT_CNT_W-1:0],
                             res_fin,
                             res_blk,
                             oprio_x[OUT_PRIO_W-1:0],
                             (res_ran ? oslot_x[2:0] : 3'd0)};
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: dv/dynamic_priority_scheduler_test.sv
// ----------------------------------------------------------------------------
// dynamic_priority_scheduler_test
// Self-checking bench: load and tick items go in through the input stream, a
// local slot-table model predicts each result item, and the output stream is
// compared field by field. Runs directed corner cases and then random
// load/tick sequences under several penalty and aging settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module dynamic_priority_scheduler_test;
  import dps_pkg::*;

  localparam int SLOTS        = SLOT_COUNT_DEF;
  localparam int PRIO_HI      = 2 ** (PRIORITY_BITS_DEF - 1) - 1;
  localparam int PRIO_LO      = -PRIO_HI - 1;
  localparam int LONG_HOLD    = 400;  // receiver hold-off, cycles
  localparam int DRAIN_CYCLES = 40;   // margin after the bench has drained
  localparam int MAX_REPORTS  = 10;
  localparam int PHASE_ITEMS  = 170;

  // one input item, unpacked from the stream fields
  typedef struct {
    logic              op;
    logic [2:0]        slot;
    logic signed [15:0] prio;
    logic [7:0]        need;
    logic signed [8:0] countdown;
    logic [7:0]        blen;
  } sched_item_t;

  // one result item
  typedef struct {
    logic              ran;
    logic [2:0]        slot;
    logic signed [15:0] prio;
    logic              blocked;
    logic              finished;
    logic [3:0]        ready;
    logic              done;
  } sched_res_t;

  // --------------------------------------------------------------------------
  // DUT connections; every input has a known value from time zero
  // --------------------------------------------------------------------------
  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // [2:0] slot, [18:3] initial_priority, [26:19] needed_time,
  // [35:27] slices_before_block, [43:36] block_length
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  // [0] operation
  logic [0:0]             s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // [2:0] running_slot, [18:3] running_priority, [19] became_blocked,
  // [20] became_finished, [24:21] ready_count, [25] all_done
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  // [0] ran
  logic [0:0]             m_axis_tuser;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [AMT_W-1:0]       cfg_data = '0;

  dynamic_priority_scheduler i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Slot table model: own copy of the table and of both registers
  // --------------------------------------------------------------------------
  status_t            slot_state     [SLOTS];
  logic signed [15:0] slot_prio      [SLOTS];
  logic [7:0]         slot_left      [SLOTS];  // remaining slices
  logic signed [8:0]  slot_countdown [SLOTS];  // run slices until block
  logic [7:0]         slot_block_left[SLOTS];
  logic [7:0]         penalty_amt;
  logic [7:0]         aging_amt;

  function automatic void clear_table();
    for (int i = 0; i < SLOTS; i++) begin
      slot_state[i]      = ST_EMPTY;
      slot_prio[i]       = '0;
      slot_left[i]       = '0;
      slot_countdown[i]  = '0;
      slot_block_left[i] = '0;
    end
    penalty_amt = RUN_PENALTY_RST;
    aging_amt   = AGING_STEP_RST;
  endfunction

  function automatic logic signed [15:0] clamp_prio(input int v);
    if (v > PRIO_HI) return PRIO_HI[15:0];
    if (v < PRIO_LO) return PRIO_LO[15:0];
    return v[15:0];
  endfunction

  // Applies one item to the table and returns the result it must produce.
  function automatic sched_res_t schedule_item(input sched_item_t it);
    sched_res_t res;
    int         run;
    int         ready_n;
    int         live_n;
    bit         goes_block;
    res     = '{default: '0};
    run     = -1;
    ready_n = 0;
    live_n  = 0;
    if (it.op == OP_LOAD) begin
      // 3-bit slot field can never exceed the table here
      slot_state[it.slot]      = ST_READY;
      slot_prio[it.slot]       = it.prio;
      slot_left[it.slot]       = it.need;
      slot_countdown[it.slot]  = it.countdown;
      slot_block_left[it.slot] = it.blen;
    end else begin
      // strict compare keeps ties on the lowest slot
      for (int i = 0; i < SLOTS; i++)
        if (slot_state[i] == ST_READY && (run < 0 || slot_prio[i] > slot_prio[run]))
          run = i;
      if (run >= 0) begin
        slot_prio[run] = clamp_prio(int'(slot_prio[run]) - int'(penalty_amt));
        if (slot_left[run] != 0) slot_left[run] = slot_left[run] - 1;
        // aging sees the ready set from the start of the tick
        for (int i = 0; i < SLOTS; i++)
          if (i != run && slot_state[i] == ST_READY)
            slot_prio[i] = clamp_prio(int'(slot_prio[i]) + int'(aging_amt));
      end
      // blocked slots count down even on an idle tick
      for (int i = 0; i < SLOTS; i++)
        if (slot_state[i] == ST_BLOCKED) begin
          if (slot_block_left[i] != 0) slot_block_left[i] = slot_block_left[i] - 1;
          if (slot_block_left[i] == 0) slot_state[i] = ST_READY;
        end
      if (run >= 0) begin
        goes_block = 1'b0;
        if (slot_countdown[run] > 0) begin
          slot_countdown[run] = slot_countdown[run] - 1;
          if (slot_countdown[run] == 0) goes_block = 1'b1;
        end
        // finishing wins over blocking
        if (slot_left[run] == 0) begin
          slot_state[run] = ST_FINISHED;
          res.finished    = 1'b1;
        end else if (goes_block) begin
          slot_state[run] = ST_BLOCKED;
          res.blocked     = 1'b1;
        end
        res.ran  = 1'b1;
        res.slot = run[2:0];
        res.prio = slot_prio[run];
      end
    end
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_state[i] == ST_READY) ready_n++;
      if (slot_state[i] == ST_READY || slot_state[i] == ST_BLOCKED) live_n++;
    end
    res.ready = ready_n[3:0];
    res.done  = (live_n == 0);
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  sched_item_t pending_items[$];    // filled by the sequence, drained by driver
  sched_res_t  awaited_results[$];  // predicted, oldest first
  sched_item_t on_bus;              // item currently offered
  int          items_queued = 0;
  int          results_seen = 0;
  int          mismatches   = 0;
  int          send_gap     = 0;
  int          recv_stall   = 0;
  int          hold_left    = 0;
  int          hold_asked   = 0;
  int          hold_taken   = 0;
  bit          quiet_phase  = 1'b0;  // no idling on either side

  // --------------------------------------------------------------------------
  // Input driver: predicts on acceptance, then offers the next item or idles.
  // tvalid gets at most one NBA per edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        awaited_results.push_back(schedule_item(on_bus));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (!quiet_phase && pending_items.size() != 0 &&
                     $urandom_range(0, 4) == 0) begin
          // start an idle burst of random length
          send_gap = $urandom_range(1, 6) - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          on_bus = pending_items.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {4'b0, on_bus.blen, on_bus.countdown, on_bus.need,
                            on_bus.prio, on_bus.slot};
          s_axis_tuser  <= on_bus.op;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Long receiver hold-off, counted here; the sequence asks for it by count
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      hold_left  <= 0;
      hold_taken <= 0;
    end else if (hold_taken != hold_asked) begin
      hold_taken <= hold_asked;
      hold_left  <= LONG_HOLD;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // --------------------------------------------------------------------------
  // Output monitor and checker, plus random back-pressure
  // --------------------------------------------------------------------------
  function automatic void field_check(input string name, input int want, input int got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("result %0d: %s expected %0d, got %0d", results_seen, name, want, got);
    end
  endfunction

  function automatic void check_result();
    sched_res_t got;
    sched_res_t want;
    got.ran      = m_axis_tuser[0];
    got.slot     = m_axis_tdata[2:0];
    got.prio     = m_axis_tdata[18:3];
    got.blocked  = m_axis_tdata[19];
    got.finished = m_axis_tdata[20];
    got.ready    = m_axis_tdata[24:21];
    got.done     = m_axis_tdata[25];
    if (awaited_results.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("result %0d: arrived with no item outstanding", results_seen);
    end else begin
      want = awaited_results.pop_front();
      field_check("ran",              want.ran,      got.ran);
      field_check("running_slot",     want.slot,     got.slot);
      field_check("running_priority", want.prio,     got.prio);
      field_check("became_blocked",   want.blocked,  got.blocked);
      field_check("became_finished",  want.finished, got.finished);
      field_check("ready_count",      want.ready,    got.ready);
      field_check("all_done",         want.done,     got.done);
    end
    results_seen++;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_result();
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
      end else if (recv_stall > 0) begin
        recv_stall--;
        m_axis_tready <= 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 4) == 0) begin
        recv_stall = $urandom_range(1, 6) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Register writes: the model takes the value on the same handshake
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_RUN_PENALTY: penalty_amt = cfg_data;
        REG_AGING_STEP:  aging_amt   = cfg_data;
        default: ;
      endcase
      cfg_valid <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence helpers
  // --------------------------------------------------------------------------
  function automatic void push_item(input logic op, input int s, input int p,
                                    input int n, input int c, input int b);
    sched_item_t it;
    it.op        = op;
    it.slot      = s[2:0];
    it.prio      = p[15:0];
    it.need      = n[7:0];
    it.countdown = c[8:0];
    it.blen      = b[7:0];
    pending_items.push_back(it);
    items_queued++;
  endfunction

  function automatic void queue_load(input int s, input int p, input int n,
                                     input int c, input int b);
    push_item(OP_LOAD, s, p, n, c, b);
  endfunction

  // payload of a tick is ignored, so it carries random content
  function automatic void queue_tick();
    push_item(OP_TICK, $urandom_range(0, 7), int'($urandom), $urandom_range(0, 255),
              $urandom_range(0, 511), $urandom_range(0, 255));
  endfunction

  // mostly short lives, small priorities for ties and values near both
  // saturation limits; "wide" draws every field over its full range
  function automatic void queue_random_load(input bit wide);
    int p;
    int n;
    int c;
    int b;
    case (wide ? 0 : $urandom_range(0, 3))
      0:       p = int'($urandom);
      1:       p = $urandom_range(0, 7);
      2:       p = PRIO_HI - $urandom_range(0, 7);
      default: p = PRIO_LO + $urandom_range(0, 7);
    endcase
    n = (wide || $urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 10);
    c = (wide || $urandom_range(0, 7) == 0) ? $urandom_range(0, 511)
                                              : $urandom_range(0, 6) - 1;
    b = (wide || $urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 5);
    queue_load($urandom_range(0, 7), p, n, c, b);
  endfunction

  // everything sent, accepted and answered; sampled away from the active edge
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_items.size() != 0 || s_axis_tvalid || awaited_results.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[7:0];
    do @(negedge clk);
    while (cfg_valid);
  endtask

  // One random phase: new register settings, then load bursts followed by
  // runs of ticks, with an occasional stretch of mixed wide-range noise.
  task automatic random_phase(input int pen, input int age, input bit hold, input bit last);
    int start;
    int n;
    wait_drained();
    write_reg(REG_RUN_PENALTY, pen);
    write_reg(REG_AGING_STEP, age);
    quiet_phase = last;
    if (hold) hold_asked++;
    start = items_queued;
    while (items_queued - start < PHASE_ITEMS) begin
      if ($urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 6);
        repeat (n) begin
          if ($urandom_range(0, 1) != 0) queue_random_load(1'b1);
          else queue_tick();
        end
      end else begin
        n = $urandom_range(1, SLOTS);
        repeat (n) queue_random_load(1'b0);
        n = $urandom_range(1, 24);
        repeat (n) queue_tick();
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    clear_table();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: penalty 3, aging 1
    queue_tick();                                // idle tick on an empty table
    queue_load(0, PRIO_HI, 0, 0, 0);             // zero time: done after one slice
    queue_tick();
    queue_load(3, PRIO_LO, 2, 1, 0);             // blocks at once, zero length
    queue_load(7, PRIO_LO, 255, -1, 255);        // ties with slot 3, never blocks
    queue_load(5, 100, 10, 2, 3);
    queue_load(5, 200, 5, -256, 1);              // overwrite a used slot
    repeat (6) queue_tick();
    queue_load(1, PRIO_HI, 255, 255, 255);
    queue_load(2, 0, 1, 1, 0);                   // finish and block together
    repeat (4) queue_tick();

    // no penalty, full aging: waiting slots pin at the top
    wait_drained();
    write_reg(REG_RUN_PENALTY, 0);
    write_reg(REG_AGING_STEP, 255);
    queue_load(4, PRIO_HI - 300, 20, 0, 0);
    queue_load(6, -100, 20, 0, 0);
    repeat (3) queue_tick();

    // full penalty, no aging: runner pins at the bottom
    wait_drained();
    write_reg(REG_RUN_PENALTY, 255);
    write_reg(REG_AGING_STEP, 0);
    queue_load(6, PRIO_LO + 300, 3, 0, 0);
    repeat (2) queue_tick();

    // random part; the first phase also holds the receiver off so the
    // block fills and stalls its input
    random_phase(RUN_PENALTY_RST, AGING_STEP_RST, 1'b1, 1'b0);
    random_phase(0, 0, 1'b0, 1'b0);
    random_phase(255, 255, 1'b0, 1'b0);
    random_phase(0, 255, 1'b0, 1'b0);
    random_phase(255, 0, 1'b0, 1'b0);
    random_phase($urandom_range(0, 255), $urandom_range(0, 255), 1'b0, 1'b1);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
